// ===== hw/rtl/lmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_pkg
// Types, register indexes and reset values for the level meter ballistics.
// ----------------------------------------------------------------------------
package lmb_pkg;

    localparam int unsigned LevelW = 16;
    localparam int unsigned CoefW  = 16;
    localparam int unsigned HoldW  = 8;
    localparam int unsigned StepW  = 12;
    localparam int unsigned IdxW   = 3;

    typedef enum logic [IdxW-1:0] {
        CFG_FLOOR_LEVEL   = 3'd0,
        CFG_INPUT_COEF    = 3'd1,
        CFG_REDUCT_COEF   = 3'd2,
        CFG_HOLD_TICKS    = 3'd3,
        CFG_DECAY_STEP    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [LevelW-1:0] floor_level;
        logic        [CoefW-1:0]  input_coef;
        logic        [CoefW-1:0]  reduct_coef;
        logic        [HoldW-1:0]  hold_ticks;
        logic        [StepW-1:0]  decay_step;
    } t_cfg;

    typedef struct packed {
        logic signed [LevelW-1:0] reduction_level;
        logic signed [LevelW-1:0] input_level;
    } t_in_beat;

    typedef struct packed {
        logic        [HoldW-1:0]  hold_left;
        logic signed [LevelW-1:0] shown_reduction;
        logic signed [LevelW-1:0] peak_level;
        logic signed [LevelW-1:0] shown_input;
    } t_out_beat;

    localparam logic signed [LevelW-1:0] FloorReset      = -16'sd15360;
    localparam logic        [CoefW-1:0]  InputCoefReset  = 16'd9830;
    localparam logic        [CoefW-1:0]  ReductCoefReset = 16'd11796;
    localparam logic        [HoldW-1:0]  HoldReset       = 8'd18;
    localparam logic        [StepW-1:0]  StepReset       = 12'd384;

    // Release step: shown + floor((level - shown) * coef / 2^16).
    function automatic logic signed [LevelW-1:0] release_step(
        input logic signed [LevelW-1:0] shown,
        input logic signed [LevelW-1:0] level,
        input logic        [CoefW-1:0]  coef
    );
        logic signed [LevelW:0]          diff;
        logic signed [LevelW+CoefW+1:0]  prod;
        logic signed [LevelW+1:0]        sum;
        diff = $signed({level[LevelW-1], level}) - $signed({shown[LevelW-1], shown});
        prod = diff * $signed({1'b0, coef});
        sum  = $signed({{2{shown[LevelW-1]}}, shown})
             + $signed(prod[LevelW+CoefW+1:CoefW]);
        return sum[LevelW-1:0];
    endfunction

endpackage

// ===== hw/rtl/level_meter_ballistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_meter_ballistics
// Peak-hold level meter ballistics for an input level and a gain reduction.
// ----------------------------------------------------------------------------
// One input beat is one meter tick: input level and gain reduction in Q8.8 dB.
// Each tick yields one output beat with the smoothed input, the held peak,
// the smoothed gain reduction and the ticks left in the peak hold.
// The input beat lands in an input register; the update is combinational
// logic from that register and the meter state into the output register,
// so one tick is taken every cycle while the receiver does not stall. The
// release multiplies set the length of that path.
// When the receiver stalls, the output beat holds, the input register keeps
// the next tick, and the input side stalls only once both are full.
// The configuration channel is always ready and should be written only while
// no tick is in flight; unknown indexes are ignored.
// Reset restores all configuration registers to their default values, sets
// both level displays and the peak to -60 dB (gain reduction to 0 dB) and
// empties the data path.
// ----------------------------------------------------------------------------
module level_meter_ballistics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] input_level, [31:16] reduction_level
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] shown_input, [31:16] peak_level, [47:32] shown_reduction,
    // [55:48] hold_left
    output logic [55:0] m_axis_tdata
);

    lmb_pkg::t_cfg      r_cfg;
    lmb_pkg::t_in_beat  r_in;
    logic               r_in_vld;
    lmb_pkg::t_out_beat r_out;
    logic               r_out_vld;

    logic signed [15:0] r_shown_in;
    logic signed [15:0] r_peak;
    logic        [7:0]  r_hold;
    logic signed [15:0] r_shown_red;

    logic signed [15:0] n_shown_in;
    logic signed [15:0] n_peak;
    logic        [7:0]  n_hold;
    logic signed [15:0] n_shown_red;
    logic signed [17:0] w_fallen;
    logic               w_load;
    logic               w_take;

    assign o_cfg_ready   = 1'b1;
    assign w_load        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_load;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_level <= lmb_pkg::FloorReset;
            r_cfg.input_coef  <= lmb_pkg::InputCoefReset;
            r_cfg.reduct_coef <= lmb_pkg::ReductCoefReset;
            r_cfg.hold_ticks  <= lmb_pkg::HoldReset;
            r_cfg.decay_step  <= lmb_pkg::StepReset;
        end else if (i_cfg_valid) begin
            case (lmb_pkg::t_cfg_idx'(i_cfg_index))
                lmb_pkg::CFG_FLOOR_LEVEL: r_cfg.floor_level <= i_cfg_data;
                lmb_pkg::CFG_INPUT_COEF:  r_cfg.input_coef  <= i_cfg_data;
                lmb_pkg::CFG_REDUCT_COEF: r_cfg.reduct_coef <= i_cfg_data;
                lmb_pkg::CFG_HOLD_TICKS:  r_cfg.hold_ticks  <= i_cfg_data[7:0];
                lmb_pkg::CFG_DECAY_STEP:  r_cfg.decay_step  <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_in.input_level > r_shown_in) begin
            n_shown_in = r_in.input_level;
        end else begin
            n_shown_in = lmb_pkg::release_step(r_shown_in, r_in.input_level,
                                               r_cfg.input_coef);
        end

        w_fallen = $signed({{2{r_peak[15]}}, r_peak})
                 - $signed({6'd0, r_cfg.decay_step});
        if (r_in.input_level >= r_peak) begin
            n_peak = r_in.input_level;
            n_hold = r_cfg.hold_ticks;
        end else if (r_hold != 8'd0) begin
            n_peak = r_peak;
            n_hold = r_hold - 8'd1;
        end else begin
            n_hold = r_hold;
            if (w_fallen > $signed({{2{r_cfg.floor_level[15]}}, r_cfg.floor_level})) begin
                n_peak = w_fallen[15:0];
            end else begin
                n_peak = r_cfg.floor_level;
            end
        end

        if (r_in.reduction_level < r_shown_red) begin
            n_shown_red = r_in.reduction_level;
        end else begin
            n_shown_red = lmb_pkg::release_step(r_shown_red, r_in.reduction_level,
                                                r_cfg.reduct_coef);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_shown_in  <= lmb_pkg::FloorReset;
            r_peak      <= lmb_pkg::FloorReset;
            r_hold      <= 8'd0;
            r_shown_red <= 16'sd0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_load) begin
                r_in_vld <= 1'b0;
            end
            if (w_load) begin
                r_out_vld   <= 1'b1;
                r_shown_in  <= n_shown_in;
                r_peak      <= n_peak;
                r_hold      <= n_hold;
                r_shown_red <= n_shown_red;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= s_axis_tdata;
        end
        if (w_load) begin
            r_out.shown_input     <= n_shown_in;
            r_out.peak_level      <= n_peak;
            r_out.shown_reduction <= n_shown_red;
            r_out.hold_left       <= n_hold;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("data path not empty after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> s_axis_tready)
        else $error("input stalled with an empty input register");

    a_input_not_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> n_shown_in >= r_in.input_level)
        else $error("input display fell below its level");

    a_reduct_not_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> n_shown_red <= r_in.reduction_level)
        else $error("reduction display rose above its level");

    a_peak_restarts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_in.input_level >= r_peak) |=>
            r_hold == $past(r_cfg.hold_ticks) && r_peak == $past(r_in.input_level))
        else $error("new peak did not restart the hold");

endmodule
